// ===== rtl/gpu_interval_stats_accumulator_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the interval statistics RTL
// ---------------------------------------------------------------------------
`ifndef GPU_INTERVAL_STATS_ACCUMULATOR_TOP_DEFINES_SVH
`define GPU_INTERVAL_STATS_ACCUMULATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// ante must imply cons at the same edge
`define GIS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante must imply cons at the following edge
`define GIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GIS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define GIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/gis_pkg.sv =====
// ---------------------------------------------------------------------------
// gis_pkg
// Types and constants of the GPU interval statistics accumulator.
// ---------------------------------------------------------------------------
package gis_pkg;

    localparam int TICK_W = 64;
    localparam int STAT_W = 2;

    typedef logic [TICK_W-1:0] t_tick;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_NESTED = 2'd1,
        ST_OVERFLOW   = 2'd2
    } t_status;

    // one checked sample on its way to the accumulator
    typedef struct packed {
        logic  nested;
        t_tick frame_dur;
        t_tick pass_dur;
    } t_sample;

endpackage

// ===== rtl/gis_front.sv =====
// ---------------------------------------------------------------------------
// gis_front
// Input register, nesting check and duration subtract, with a sample register.
// ---------------------------------------------------------------------------
`include "gpu_interval_stats_accumulator_top_defines.svh"

module gis_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gis_pkg::t_tick   i_frame_start_time,
    input  gis_pkg::t_tick   i_pass_start_time,
    input  gis_pkg::t_tick   i_pass_stop_time,
    input  gis_pkg::t_tick   i_frame_stop_time,
    output logic             o_smp_valid,
    output gis_pkg::t_sample o_smp,
    input  logic             i_dn_ready
);
    import gis_pkg::*;

    logic    r_ts_valid;
    logic    r_smp_valid;
    t_tick   r_fb, r_pb, r_pe, r_fe;
    t_sample r_smp;
    t_sample n_smp;
    logic    ts_ready;
    logic    smp_ready;

    assign smp_ready  = !r_smp_valid || i_dn_ready;
    assign ts_ready   = !r_ts_valid || smp_ready;
    assign o_in_ready = ts_ready;

    always_comb begin
        n_smp.nested    = (r_fb <= r_pb) && (r_pb <= r_pe) && (r_pe <= r_fe);
        n_smp.frame_dur = r_fe - r_fb;
        n_smp.pass_dur  = r_pe - r_pb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_valid  <= 1'b0;
            r_smp_valid <= 1'b0;
        end else begin
            if (ts_ready) begin
                r_ts_valid <= i_in_valid;
            end
            if (smp_ready) begin
                r_smp_valid <= r_ts_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ts_ready && i_in_valid) begin
            r_fb <= i_frame_start_time;
            r_pb <= i_pass_start_time;
            r_pe <= i_pass_stop_time;
            r_fe <= i_frame_stop_time;
        end
        if (smp_ready && r_ts_valid) begin
            r_smp <= n_smp;
        end
    end

    assign o_smp_valid = r_smp_valid;
    assign o_smp       = r_smp;

    // a nested pass can never outlast its frame
    `GIS_ASSERT_IMPLY(a_pass_within_frame, i_clk, i_rst_n,
        r_smp_valid && r_smp.nested, r_smp.pass_dur <= r_smp.frame_dur,
        "pass duration exceeds frame duration")

endmodule

// ===== rtl/gis_accum.sv =====
// ---------------------------------------------------------------------------
// gis_accum
// Overflow check, running statistics and the result register.
// ---------------------------------------------------------------------------
`include "gpu_interval_stats_accumulator_top_defines.svh"

module gis_accum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_smp_valid,
    input  gis_pkg::t_sample          i_smp,
    output logic                      o_smp_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [gis_pkg::STAT_W-1:0] o_status,
    output gis_pkg::t_tick            o_frame_duration,
    output gis_pkg::t_tick            o_pass_duration,
    output gis_pkg::t_tick            o_samples_taken,
    output gis_pkg::t_tick            o_frame_sum,
    output gis_pkg::t_tick            o_frame_least,
    output gis_pkg::t_tick            o_frame_most,
    output gis_pkg::t_tick            o_pass_sum,
    output gis_pkg::t_tick            o_pass_least,
    output gis_pkg::t_tick            o_pass_most
);
    import gis_pkg::*;

    // running statistics; they only move when a result is loaded, so they
    // double as the statistics half of the result register
    t_tick   r_count, r_ftot, r_fmin, r_fmax, r_ptot, r_pmin, r_pmax;
    logic    r_out_valid;
    t_status r_status;
    t_tick   r_fdur, r_pdur;

    logic [TICK_W:0] frame_add;
    logic [TICK_W:0] pass_add;
    logic            ovf;
    logic            out_ready;
    logic            take;
    logic            upd;
    t_status         n_status;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign take        = i_smp_valid && out_ready;
    assign o_smp_ready = out_ready;

    always_comb begin
        frame_add = {1'b0, r_ftot} + {1'b0, i_smp.frame_dur};
        pass_add  = {1'b0, r_ptot} + {1'b0, i_smp.pass_dur};
        ovf       = (&r_count) || frame_add[TICK_W] || pass_add[TICK_W];
        if (!i_smp.nested) begin
            n_status = ST_NOT_NESTED;
        end else if (ovf) begin
            n_status = ST_OVERFLOW;
        end else begin
            n_status = ST_OK;
        end
        upd = take && (n_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_ftot      <= '0;
            r_fmin      <= '0;
            r_fmax      <= '0;
            r_ptot      <= '0;
            r_pmin      <= '0;
            r_pmax      <= '0;
        end else begin
            if (out_ready) begin
                r_out_valid <= i_smp_valid;
            end
            if (upd) begin
                r_count <= r_count + t_tick'(1);
                r_ftot  <= frame_add[TICK_W-1:0];
                r_ptot  <= pass_add[TICK_W-1:0];
                // first sample seeds the minimums directly
                if (r_count == '0 || i_smp.frame_dur < r_fmin) begin
                    r_fmin <= i_smp.frame_dur;
                end
                if (r_count == '0 || i_smp.pass_dur < r_pmin) begin
                    r_pmin <= i_smp.pass_dur;
                end
                if (i_smp.frame_dur > r_fmax) begin
                    r_fmax <= i_smp.frame_dur;
                end
                if (i_smp.pass_dur > r_pmax) begin
                    r_pmax <= i_smp.pass_dur;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status <= n_status;
            r_fdur   <= (n_status == ST_OK) ? i_smp.frame_dur : '0;
            r_pdur   <= (n_status == ST_OK) ? i_smp.pass_dur : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_frame_duration = r_fdur;
    assign o_pass_duration  = r_pdur;
    assign o_samples_taken  = r_count;
    assign o_frame_sum      = r_ftot;
    assign o_frame_least    = r_fmin;
    assign o_frame_most     = r_fmax;
    assign o_pass_sum       = r_ptot;
    assign o_pass_least     = r_pmin;
    assign o_pass_most      = r_pmax;

    `GIS_ASSERT_IMPLY(a_empty_stats, i_clk, i_rst_n,
        r_count == '0,
        r_ftot == '0 && r_ptot == '0 && r_fmin == '0 && r_fmax == '0 &&
        r_pmin == '0 && r_pmax == '0,
        "statistics nonzero with no accepted sample")

    `GIS_ASSERT_IMPLY(a_min_le_max, i_clk, i_rst_n,
        r_count != '0, r_fmin <= r_fmax && r_pmin <= r_pmax,
        "minimum above maximum")

    `GIS_ASSERT_IMPLY(a_err_zero_dur, i_clk, i_rst_n,
        r_out_valid && r_status != ST_OK, r_fdur == '0 && r_pdur == '0,
        "rejected request reports nonzero duration")

    `GIS_ASSERT_NEXT(a_stall_holds_stats, i_clk, i_rst_n,
        r_out_valid && i_out_stall, $stable(r_count) && $stable(r_ftot) && $stable(r_ptot),
        "statistics moved under a stalled result")

endmodule

// ===== rtl/gpu_interval_stats_accumulator_top.sv =====
// ---------------------------------------------------------------------------
// gpu_interval_stats_accumulator_top
// Running count, sum, min and max of GPU frame and pass durations.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one request per frame carries four 64-bit timestamps
//   (frame begin, pass begin, pass end, frame end). A request is taken on a
//   rising edge with i_in_valid high and o_in_stall low.
//   Output channel: exactly one result per request, taken on a rising edge
//   with o_out_valid high and i_out_stall low. The result carries a status
//   (ok, not nested, would overflow), the two durations (zero unless ok) and
//   the running statistics after that request.
//   Path: a request passes the input register, the sample register and the
//   result register in that order; i_out_stall can hold it in any of them.
//   Throughput: one request per cycle while the result side does not stall;
//   the running statistics close their loop through one 65-bit add per total.
//   Stall: i_out_stall holds the result and the statistics; the two front
//   registers still fill, after which o_in_stall rises in the same cycle.
//   Reset (i_rst_n low, synchronous): pipeline emptied, count, totals,
//   minimums and maximums cleared to zero.
// ---------------------------------------------------------------------------
module gpu_interval_stats_accumulator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gis_pkg::t_tick             i_frame_start_time,
    input  gis_pkg::t_tick             i_pass_start_time,
    input  gis_pkg::t_tick             i_pass_stop_time,
    input  gis_pkg::t_tick             i_frame_stop_time,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [gis_pkg::STAT_W-1:0] o_status,
    output gis_pkg::t_tick             o_frame_duration,
    output gis_pkg::t_tick             o_pass_duration,
    output gis_pkg::t_tick             o_samples_taken,
    output gis_pkg::t_tick             o_frame_sum,
    output gis_pkg::t_tick             o_frame_least,
    output gis_pkg::t_tick             o_frame_most,
    output gis_pkg::t_tick             o_pass_sum,
    output gis_pkg::t_tick             o_pass_least,
    output gis_pkg::t_tick             o_pass_most
);
    import gis_pkg::*;

    logic    in_ready;
    logic    smp_valid;
    logic    smp_ready;
    t_sample smp;

    // stall is the inverse of the front's ready chain
    assign o_in_stall = !in_ready;

    // nesting check and durations
    gis_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (in_ready),
        .i_frame_start_time (i_frame_start_time),
        .i_pass_start_time  (i_pass_start_time),
        .i_pass_stop_time   (i_pass_stop_time),
        .i_frame_stop_time  (i_frame_stop_time),
        .o_smp_valid        (smp_valid),
        .o_smp              (smp),
        .i_dn_ready         (smp_ready)
    );

    // overflow check, statistics update, result register
    gis_accum u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_smp_valid      (smp_valid),
        .i_smp            (smp),
        .o_smp_ready      (smp_ready),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_frame_duration (o_frame_duration),
        .o_pass_duration  (o_pass_duration),
        .o_samples_taken  (o_samples_taken),
        .o_frame_sum      (o_frame_sum),
        .o_frame_least    (o_frame_least),
        .o_frame_most     (o_frame_most),
        .o_pass_sum       (o_pass_sum),
        .o_pass_least     (o_pass_least),
        .o_pass_most      (o_pass_most)
    );

endmodule

// ===== dv/gpu_interval_stats_accumulator_top_test.sv =====
// ---------------------------------------------------------------------------
// gpu_interval_stats_accumulator_top_test
// Self-checking bench for the frame/pass interval statistics block. A short
// table of hand-picked frames, some with hand-written results, is followed
// by random frames, first with small durations and then with large ones
// that push the running totals into overflow. Every result is compared
// field by field against a hand-written result or a model of the statistics.
// Both channels idle at random, and the result side holds off twice for
// long stretches so that the pipeline fills and stalls its input.
// ---------------------------------------------------------------------------
module gpu_interval_stats_accumulator_top_test;
    import gis_pkg::*;

    localparam t_tick TICK_MAX      = '1;
    localparam t_tick TOP_BIT       = 64'h8000_0000_0000_0000;
    localparam int    RANDOM_FRAMES = 1200;
    localparam int    LATE_FRAMES   = 300;   // tail that drives the totals to overflow
    localparam int    HOLD_CYCLES   = 64;

    // one result as the block should report it
    typedef struct packed {
        t_status status;
        t_tick   frame_len;
        t_tick   pass_len;
        t_tick   samples;
        t_tick   frame_sum;
        t_tick   frame_least;
        t_tick   frame_most;
        t_tick   pass_sum;
        t_tick   pass_least;
        t_tick   pass_most;
    } t_interval_result;

    typedef struct {
        t_tick            frame_start;
        t_tick            pass_start;
        t_tick            pass_stop;
        t_tick            frame_stop;
        bit               typed;        // want is hand-written, else predicted
        t_interval_result want;
    } t_frame_row;

    // statistics after the single accepted frame (30, 5) of the table
    localparam t_interval_result HELD_OVERFLOW = '{ST_OVERFLOW, 64'd0, 64'd0, 64'd1,
        64'd30, 64'd30, 64'd30, 64'd5, 64'd5, 64'd5};
    localparam t_interval_result HELD_NOT_NESTED = '{ST_NOT_NESTED, 64'd0, 64'd0, 64'd1,
        64'd30, 64'd30, 64'd30, 64'd5, 64'd5, 64'd5};

    logic  i_clk              = 1'b0;
    logic  i_rst_n            = 1'b0;
    logic  i_in_valid         = 1'b0;
    logic  o_in_stall;
    t_tick i_frame_start_time = '0;
    t_tick i_pass_start_time  = '0;
    t_tick i_pass_stop_time   = '0;
    t_tick i_frame_stop_time  = '0;
    logic  o_out_valid;
    logic  i_out_stall        = 1'b0;
    logic [STAT_W-1:0] o_status;
    t_tick o_frame_duration;
    t_tick o_pass_duration;
    t_tick o_samples_taken;
    t_tick o_frame_sum;
    t_tick o_frame_least;
    t_tick o_frame_most;
    t_tick o_pass_sum;
    t_tick o_pass_least;
    t_tick o_pass_most;

    // sideband that travels with the request currently on the input
    bit               req_typed = 1'b0;
    t_interval_result req_want  = '0;

    // running statistics as the bench expects them
    t_tick tally_count      = '0;
    t_tick tally_frame_sum  = '0;
    t_tick tally_frame_min  = '0;
    t_tick tally_frame_max  = '0;
    t_tick tally_pass_sum   = '0;
    t_tick tally_pass_min   = '0;
    t_tick tally_pass_max   = '0;

    t_interval_result expected_results[$];
    int unsigned      results_taken = 0;
    int unsigned      mismatches    = 0;
    bit               calm          = 1'b0;   // no idling on either side

    t_frame_row directed_frames [16] = '{
        // nesting broken before anything was accepted: all statistics zero
        '{64'd5, 64'd4, 64'd6, 64'd9, 1'b1, '{ST_NOT_NESTED, 64'd0, 64'd0, 64'd0,
            64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0}},
        // first acceptance: minimums take the durations directly
        '{64'd10, 64'd20, 64'd25, 64'd40, 1'b1, '{ST_OK, 64'd30, 64'd5, 64'd1,
            64'd30, 64'd30, 64'd30, 64'd5, 64'd5, 64'd5}},
        // full-range frames no longer fit in the frame total
        '{64'd0, 64'd0, 64'd0, TICK_MAX, 1'b1, HELD_OVERFLOW},
        '{64'd0, TICK_MAX, TICK_MAX, TICK_MAX, 1'b1, HELD_OVERFLOW},
        '{64'd0, 64'd0, TICK_MAX, TICK_MAX, 1'b1, HELD_OVERFLOW},
        // one tick more than the room left
        '{64'd29, 64'd29, 64'd29, TICK_MAX, 1'b1, HELD_OVERFLOW},
        // each of the three nesting violations at the extremes
        '{TICK_MAX, 64'd0, 64'd0, 64'd0, 1'b1, HELD_NOT_NESTED},
        '{64'd0, 64'd0, TICK_MAX, 64'd0, 1'b1, HELD_NOT_NESTED},
        '{64'd0, TICK_MAX, 64'd0, TICK_MAX, 1'b1, HELD_NOT_NESTED},
        '{64'd1, 64'd1, 64'd1, TICK_MAX, 1'b0, '0},
        // pass edges equal to frame edges
        '{64'd1000, 64'd1000, 64'd1007, 64'd1007, 1'b0, '0},
        '{64'd200, 64'd250, 64'd260, 64'd300, 1'b0, '0},
        '{TICK_MAX - 50, TICK_MAX - 40, TICK_MAX - 1, TICK_MAX, 1'b0, '0},
        // off-by-one nesting violations, then a nested frame across the top bit
        '{64'd7, 64'd6, 64'd6, 64'd7, 1'b0, '0},
        '{64'd6, 64'd6, 64'd8, 64'd7, 1'b0, '0},
        '{TOP_BIT - 2, TOP_BIT, TOP_BIT + 1, TOP_BIT + 1, 1'b0, '0}
    };

    gpu_interval_stats_accumulator_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_frame_start_time (i_frame_start_time),
        .i_pass_start_time  (i_pass_start_time),
        .i_pass_stop_time   (i_pass_stop_time),
        .i_frame_stop_time  (i_frame_stop_time),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_frame_duration   (o_frame_duration),
        .o_pass_duration    (o_pass_duration),
        .o_samples_taken    (o_samples_taken),
        .o_frame_sum        (o_frame_sum),
        .o_frame_least      (o_frame_least),
        .o_frame_most       (o_frame_most),
        .o_pass_sum         (o_pass_sum),
        .o_pass_least       (o_pass_least),
        .o_pass_most        (o_pass_most)
    );

    always #1 i_clk = ~i_clk;

    // Applies one frame to the running statistics and returns the result
    // the block should report for it. Rejected frames leave the state alone.
    function automatic t_interval_result accumulate_interval(t_tick frame_start,
                                                             t_tick pass_start,
                                                             t_tick pass_stop,
                                                             t_tick frame_stop);
        t_interval_result r;
        t_tick            frame_len;
        t_tick            pass_len;
        r         = '0;
        frame_len = frame_stop - frame_start;
        pass_len  = pass_stop - pass_start;
        if (frame_start > pass_start || pass_start > pass_stop || pass_stop > frame_stop) begin
            r.status = ST_NOT_NESTED;
        end else if (tally_count == TICK_MAX || frame_len > ~tally_frame_sum ||
                     pass_len > ~tally_pass_sum) begin
            // ~sum is the room left below all ones
            r.status = ST_OVERFLOW;
        end else begin
            r.status    = ST_OK;
            r.frame_len = frame_len;
            r.pass_len  = pass_len;
            if (tally_count == '0 || frame_len < tally_frame_min) tally_frame_min = frame_len;
            if (tally_count == '0 || pass_len < tally_pass_min) tally_pass_min = pass_len;
            if (frame_len > tally_frame_max) tally_frame_max = frame_len;
            if (pass_len > tally_pass_max) tally_pass_max = pass_len;
            tally_frame_sum = tally_frame_sum + frame_len;
            tally_pass_sum  = tally_pass_sum + pass_len;
            tally_count     = tally_count + 64'd1;
        end
        r.samples     = tally_count;
        r.frame_sum   = tally_frame_sum;
        r.frame_least = tally_frame_min;
        r.frame_most  = tally_frame_max;
        r.pass_sum    = tally_pass_sum;
        r.pass_least  = tally_pass_min;
        r.pass_most   = tally_pass_max;
        return r;
    endfunction

    // uniform over 0..lim
    function automatic t_tick rand_upto(t_tick lim);
        t_tick r;
        r = {$urandom, $urandom};
        if (lim == TICK_MAX) return r;
        return r % (lim + 1);
    endfunction

    // random value of at most n significant bits
    function automatic t_tick rand_bits(int unsigned n);
        if (n == 0) return '0;
        return {$urandom, $urandom} >> (64 - n);
    endfunction

    // Random frame. Early frames keep durations short so the totals stay far
    // from the top; late ones are large, fill the frame total exactly, miss it
    // by one tick or are short. About one in ten frames is malformed.
    task automatic make_random_frame(input bit late, output t_tick frame_start,
                                     output t_tick pass_start, output t_tick pass_stop,
                                     output t_tick frame_stop);
        t_tick       frame_len;
        t_tick       pass_len;
        t_tick       swap;
        int unsigned pick;
        pick = $urandom_range(99);
        if (!late) begin
            frame_len = rand_bits($urandom_range(40, 1));
            pass_len  = rand_upto(frame_len);
        end else if (pick < 40) begin
            frame_len = rand_bits($urandom_range(64, 58));
            pass_len  = rand_upto(frame_len);
        end else if (pick < 48) begin
            frame_len = ~tally_frame_sum;
            pass_len  = rand_upto(frame_len < ~tally_pass_sum ? frame_len : ~tally_pass_sum);
        end else if (pick < 56) begin
            frame_len = ~tally_frame_sum + 1;
            pass_len  = rand_upto(frame_len);
        end else begin
            frame_len = rand_bits($urandom_range(16, 0));
            pass_len  = rand_upto(frame_len);
        end
        frame_start = rand_upto(TICK_MAX - frame_len);
        pass_start  = frame_start + rand_upto(frame_len - pass_len);
        pass_stop   = pass_start + pass_len;
        frame_stop  = frame_start + frame_len;
        if (pick >= 90) begin
            case ($urandom_range(3))
                0: begin
                    frame_start = rand_upto(TICK_MAX);
                    pass_start  = rand_upto(TICK_MAX);
                    pass_stop   = rand_upto(TICK_MAX);
                    frame_stop  = rand_upto(TICK_MAX);
                end
                1: begin
                    swap        = frame_start;
                    frame_start = pass_start;
                    pass_start  = swap;
                end
                2: begin
                    swap       = pass_start;
                    pass_start = pass_stop;
                    pass_stop  = swap;
                end
                default: begin
                    swap       = pass_stop;
                    pass_stop  = frame_stop;
                    frame_stop = swap;
                end
            endcase
        end
    endtask

    // Called just after a rising edge; returns at a falling edge with valid
    // low for zero or more of the preceding cycles.
    task automatic pause_sender();
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // Drives one request and holds it until the block takes it.
    task automatic offer_request(t_tick frame_start, t_tick pass_start, t_tick pass_stop,
                                 t_tick frame_stop, bit typed, t_interval_result want);
        i_in_valid         <= 1'b1;
        i_frame_start_time <= frame_start;
        i_pass_start_time  <= pass_start;
        i_pass_stop_time   <= pass_stop;
        i_frame_stop_time  <= frame_stop;
        req_typed          <= typed;
        req_want           <= want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic check_field(string field, t_tick want, t_tick got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected %h got %h", results_taken, field, want, got);
        end
    endtask

    // Every accepted request queues one expected result. Hand-written rows
    // override the model, which still advances its state.
    always @(posedge i_clk) begin : request_monitor
        t_interval_result predicted;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predicted = accumulate_interval(i_frame_start_time, i_pass_start_time,
                                            i_pass_stop_time, i_frame_stop_time);
            expected_results.push_back(req_typed ? req_want : predicted);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_interval_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_taken++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no request outstanding", results_taken);
            end else begin
                want = expected_results.pop_front();
                check_field("status", t_tick'(want.status), t_tick'(o_status));
                check_field("frame_duration", want.frame_len, o_frame_duration);
                check_field("pass_duration", want.pass_len, o_pass_duration);
                check_field("samples_taken", want.samples, o_samples_taken);
                check_field("frame_sum", want.frame_sum, o_frame_sum);
                check_field("frame_least", want.frame_least, o_frame_least);
                check_field("frame_most", want.frame_most, o_frame_most);
                check_field("pass_sum", want.pass_sum, o_pass_sum);
                check_field("pass_least", want.pass_least, o_pass_least);
                check_field("pass_most", want.pass_most, o_pass_most);
            end
        end
    end

    // Result side: random stalls, plus two long hold-offs so the pipeline
    // backs up into o_in_stall while requests keep coming.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned holds_done;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < 2 &&
                results_taken >= 150 + 600 * holds_done) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!i_rst_n || calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 23);
            end
        end
    end

    initial begin : stimulus
        t_tick frame_start;
        t_tick pass_start;
        t_tick pass_stop;
        t_tick frame_stop;
        int    n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_frames[k]) begin
            pause_sender();
            offer_request(directed_frames[k].frame_start, directed_frames[k].pass_start,
                          directed_frames[k].pass_stop, directed_frames[k].frame_stop,
                          directed_frames[k].typed, directed_frames[k].want);
        end
        for (n = 0; n < RANDOM_FRAMES; n++) begin
            // back-to-back traffic on both sides for a stretch
            calm = (n >= 300 && n < 500);
            pause_sender();
            make_random_frame(n >= RANDOM_FRAMES - LATE_FRAMES,
                              frame_start, pass_start, pass_stop, frame_stop);
            offer_request(frame_start, pass_start, pass_stop, frame_stop, 1'b0, '0);
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // three-stage pipeline: catch anything extra that trails out
        repeat (12) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gis_pkg.sv
rtl/gis_front.sv
rtl/gis_accum.sv
rtl/gpu_interval_stats_accumulator_top.sv
dv/gpu_interval_stats_accumulator_top_test.sv
